[hw/rtl/rprs_pkg.sv]
// Shared constants, types and helper functions for the parity recovery / unstripe block.
package rprs_pkg;

	localparam int MAX_DISKS      = 6;
	localparam int MAX_BLOCK_BITS = 16;
	localparam int NIBBLE_BITS    = 4;

	localparam int SYM_W      = 2;
	localparam int DC_W       = 3;
	localparam int BB_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam int COL_W   = $clog2(MAX_BLOCK_BITS);
	localparam int CNT_W   = $clog2(MAX_BLOCK_BITS + 1);
	localparam int DISK_W  = $clog2(MAX_DISKS);
	localparam int REM_W   = $clog2((MAX_DISKS - 1) * MAX_BLOCK_BITS + 1);
	localparam int FILL_W  = $clog2(NIBBLE_BITS);
	localparam int SHAMT_W = FILL_W + 1;

	// symbol bit that marks an erasure (codes two and three)
	localparam int SYM_ERASE = 1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [DC_W-1:0] DC_RESET = DC_W'(6);
	localparam logic [BB_W-1:0] BB_RESET = BB_W'(16);
	localparam logic            PO_RESET = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISK_COUNT = 2'd0,
		REG_BLOCK_BITS = 2'd1,
		REG_PARITY_ODD = 2'd2
	} cfg_reg_t;

	// stripe store / serializer control
	typedef struct packed {
		logic              wr;
		logic [COL_W-1:0]  col;
		logic              load;
		logic              shift;
		logic [DISK_W-1:0] disk;
	} stripe_ctl_t;

	// nibble packer commands
	typedef struct packed {
		logic push;
		logic bit_val;
		logic last;
		logic pad;
		logic status;
		logic status_ok;
	} pack_cmd_t;

	function automatic logic [DC_W-1:0] eff_disks(input logic [DC_W-1:0] dc);
		logic [DC_W-1:0] r;
		begin
			r = dc;
			if (dc < DC_W'(2))
				r = DC_W'(2);
			else if (dc > DC_W'(MAX_DISKS))
				r = DC_W'(MAX_DISKS);
			return r;
		end
	endfunction

	function automatic logic [CNT_W-1:0] eff_bits(input logic [BB_W-1:0] bb);
		logic [CNT_W-1:0] r;
		begin
			r = CNT_W'(bb);
			if (bb == '0)
				r = CNT_W'(1);
			else if (BB_W'(bb) > BB_W'(MAX_BLOCK_BITS))
				r = CNT_W'(MAX_BLOCK_BITS);
			return r;
		end
	endfunction

endpackage

[hw/rtl/rprs_repair.sv]
// Column repair: single-erasure rebuild from parity and the invalid condition.
module rprs_repair (
	input  logic [rprs_pkg::MAX_DISKS-1:0][rprs_pkg::SYM_W-1:0] sym,
	input  logic [rprs_pkg::DC_W-1:0]                          dc,
	input  logic                                               parity_odd,
	output logic [rprs_pkg::MAX_DISKS-1:0]                     bits,
	output logic                                               bad
);
	import rprs_pkg::*;

	logic [MAX_DISKS-1:0] er;
	logic [MAX_DISKS-1:0] raw;
	logic                 multi;
	logic                 single;
	logic                 mismatch;

	always_comb begin
		for (int j = 0; j < MAX_DISKS; j++) begin
			er[j]  = (DC_W'(j) < dc) && sym[j][SYM_ERASE];
			raw[j] = (DC_W'(j) < dc) && !sym[j][SYM_ERASE] && sym[j][0];
		end
	end

	// more than one bit set: clear lowest and test the rest
	assign multi    = |(er & (er - 1'b1));
	assign single   = (|er) && !multi;
	assign mismatch = (^raw) != parity_odd;

	assign bits = raw | ({MAX_DISKS{single && mismatch}} & er);
	assign bad  = multi || (!(|er) && mismatch);

endmodule

[hw/rtl/rprs_stripe.sv]
// Stripe store with a bit-serial readout shift register.
module rprs_stripe (
	input  logic                                 clk,
	input  rprs_pkg::stripe_ctl_t                ctl,
	input  logic [rprs_pkg::MAX_DISKS-1:0]       col_bits,
	output logic                                 sbit
);
	import rprs_pkg::*;

	logic [MAX_BLOCK_BITS-1:0] stripe_q [MAX_DISKS];
	logic [MAX_BLOCK_BITS-1:0] sh_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			for (int j = 0; j < MAX_DISKS; j++)
				stripe_q[j][ctl.col] <= col_bits[j];
		end
		if (ctl.load)
			sh_q <= stripe_q[ctl.disk];
		else if (ctl.shift)
			sh_q <= sh_q >> 1;
	end

	// first column leaves first
	assign sbit = sh_q[0];

endmodule

[hw/rtl/rprs_packer.sv]
// Nibble packer and output register.
module rprs_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rprs_pkg::pack_cmd_t           cmd,
	input  logic                          out_stall,
	output logic                          avail,
	output logic                          out_valid,
	output logic                          item_kind,
	output logic [rprs_pkg::NIBBLE_BITS-1:0] nibble,
	output logic                          set_valid,
	output logic                          last_result
);
	import rprs_pkg::*;

	logic [NIBBLE_BITS-1:0] acc_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   ov_q;
	logic                   kind_q;
	logic [NIBBLE_BITS-1:0] nib_q;
	logic                   sv_q;
	logic                   lr_q;

	logic [NIBBLE_BITS-1:0] acc_next;
	logic [NIBBLE_BITS-1:0] pad_nib;
	logic                   full_now;
	logic                   emit;

	assign avail    = !ov_q || !out_stall;
	assign acc_next = {acc_q[NIBBLE_BITS-2:0], cmd.bit_val};
	assign pad_nib  = acc_q << (SHAMT_W'(NIBBLE_BITS) - SHAMT_W'(fill_q));
	assign full_now = cmd.push && (fill_q == FILL_W'(NIBBLE_BITS - 1));
	assign emit     = full_now || (cmd.pad && (fill_q != '0)) || cmd.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			acc_q  <= '0;
			fill_q <= '0;
		end else begin
			if (emit)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;

			if (cmd.push && !full_now) begin
				acc_q  <= acc_next;
				fill_q <= fill_q + 1'b1;
			end else if (full_now || cmd.pad || cmd.status) begin
				acc_q  <= '0;
				fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (full_now) begin
			kind_q <= KIND_DATA;
			nib_q  <= acc_next;
			sv_q   <= 1'b0;
			lr_q   <= cmd.last;
		end else if (cmd.pad && (fill_q != '0)) begin
			kind_q <= KIND_DATA;
			nib_q  <= pad_nib;
			sv_q   <= 1'b0;
			lr_q   <= 1'b0;
		end else if (cmd.status) begin
			kind_q <= KIND_STATUS;
			nib_q  <= '0;
			sv_q   <= cmd.status_ok;
			lr_q   <= 1'b1;
		end
	end

	assign out_valid   = ov_q;
	assign item_kind   = kind_q;
	assign nibble      = nib_q;
	assign set_valid   = sv_q;
	assign last_result = lr_q;

endmodule

[hw/rtl/raid_parity_recover_unstripe_core.sv]
// Top level: RAID parity erasure recovery and stripe unstriping, bit-serial drain.
// A column is repaired and stored in the cycle it is accepted. A column that
//   closes a stripe (or is the last column) starts a drain: each data disk in turn is loaded
//   into the stripe shift register and shifted out one data bit per cycle while the output
//   is not stalled; the last column adds a pad step and a status step.
// Throughput: one column per cycle inside a stripe; the item that closes a stripe holds
//   input until the drain is done. Output stalls pause the drain bit by bit.
// Reset (arst_n low, async): control clears, registers return to 6 disks, 16 bits, even.
module raid_parity_recover_unstripe_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// column input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rprs_pkg::SYM_W-1:0]         disk0_sym,
	input  logic [rprs_pkg::SYM_W-1:0]         disk1_sym,
	input  logic [rprs_pkg::SYM_W-1:0]         disk2_sym,
	input  logic [rprs_pkg::SYM_W-1:0]         disk3_sym,
	input  logic [rprs_pkg::SYM_W-1:0]         disk4_sym,
	input  logic [rprs_pkg::SYM_W-1:0]         disk5_sym,
	input  logic                               last_column,
	// result output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               item_kind,
	output logic [rprs_pkg::NIBBLE_BITS-1:0]   nibble,
	output logic                               set_valid,
	output logic                               last_result,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rprs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rprs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rprs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_PAD,
		ST_STATUS
	} state_t;

	// parity rotation: index is at most five, so two conditional subtracts suffice
	function automatic logic [DC_W-1:0] mod_small(input logic [DC_W-1:0] a,
	                                              input logic [DC_W-1:0] m);
		logic [DC_W-1:0] r;
		begin
			r = a;
			if (r >= m)
				r = r - m;
			if (r >= m)
				r = r - m;
			return r;
		end
	endfunction

	state_t           state_q;
	logic [DC_W-1:0]  dc_cfg_q;
	logic [BB_W-1:0]  bb_cfg_q;
	logic             po_cfg_q;

	logic [COL_W-1:0] col_q;      // next column within the stripe
	logic [DC_W-1:0]  pidx_q;     // rotating parity disk
	logic             inv_q;      // sticky invalid
	logic             last_q;     // current item is the last column
	logic [DC_W-1:0]  skip_q;     // parity disk of the stripe in drain
	logic [DC_W-1:0]  disk_q;     // disk being drained
	logic [CNT_W-1:0] cols_q;     // columns in the stripe being drained
	logic [CNT_W-1:0] k_q;        // bits left on this disk
	logic [REM_W-1:0] rem_q;      // bits left in the whole drain

	logic [DC_W-1:0]            dc_eff;
	logic [CNT_W-1:0]           bb_eff;
	logic [CNT_W-1:0]           bb_m1;
	logic [COL_W-1:0]           col_sel;
	logic [CNT_W-1:0]           colcnt;
	logic                       drain_go;
	logic [REM_W-1:0]           rem_init;
	logic                       in_fire;
	logic                       avail;
	logic                       sbit;
	logic [MAX_DISKS-1:0]       rep_bits;
	logic                       rep_bad;
	logic [MAX_DISKS-1:0][SYM_W-1:0] syms;
	stripe_ctl_t                sctl;
	pack_cmd_t                  pcmd;

	assign dc_eff = eff_disks(dc_cfg_q);
	assign bb_eff = eff_bits(bb_cfg_q);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign syms = {disk5_sym, disk4_sym, disk3_sym, disk2_sym, disk1_sym, disk0_sym};

	// a shrunk block_bits mid-stripe pins the write to the last column
	assign bb_m1    = bb_eff - 1'b1;
	assign col_sel  = (CNT_W'(col_q) >= bb_m1) ? bb_m1[COL_W-1:0] : col_q;
	assign colcnt   = CNT_W'(col_sel) + 1'b1;
	assign drain_go = (colcnt >= bb_eff) || last_column;
	assign rem_init = REM_W'(REM_W'(dc_eff - 1'b1) * REM_W'(colcnt));

	rprs_repair u_repair (
		.sym        (syms),
		.dc         (dc_eff),
		.parity_odd (po_cfg_q),
		.bits       (rep_bits),
		.bad        (rep_bad)
	);

	rprs_stripe u_stripe (
		.clk      (clk),
		.ctl      (sctl),
		.col_bits (rep_bits),
		.sbit     (sbit)
	);

	rprs_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (pcmd),
		.out_stall   (out_stall),
		.avail       (avail),
		.out_valid   (out_valid),
		.item_kind   (item_kind),
		.nibble      (nibble),
		.set_valid   (set_valid),
		.last_result (last_result)
	);

	// datapath commands for the current state
	always_comb begin
		sctl      = '0;
		pcmd      = '0;
		sctl.wr   = in_fire;
		sctl.col  = col_sel;
		sctl.disk = disk_q[DISK_W-1:0];
		case (state_q)
			ST_LOAD: begin
				sctl.load = (disk_q < dc_eff) && (disk_q != skip_q);
			end
			ST_SHIFT: begin
				sctl.shift   = avail;
				pcmd.push    = avail;
				pcmd.bit_val = sbit;
				// a nibble completed with fewer than four bits to follow is the item's last, unless the item is the last column
				pcmd.last    = !last_q && (rem_q <= REM_W'(NIBBLE_BITS));
			end
			ST_PAD: begin
				pcmd.pad = avail;
			end
			ST_STATUS: begin
				pcmd.status    = avail;
				pcmd.status_ok = !inv_q;
			end
			default: begin
				sctl.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dc_cfg_q <= DC_RESET;
			bb_cfg_q <= BB_RESET;
			po_cfg_q <= PO_RESET;
			col_q    <= '0;
			pidx_q   <= '0;
			inv_q    <= 1'b0;
			last_q   <= 1'b0;
			skip_q   <= '0;
			disk_q   <= '0;
			cols_q   <= '0;
			k_q      <= '0;
			rem_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_DISK_COUNT: dc_cfg_q <= cfg_data[DC_W-1:0];
					REG_BLOCK_BITS: bb_cfg_q <= cfg_data[BB_W-1:0];
					REG_PARITY_ODD: po_cfg_q <= cfg_data[0];
					default:        po_cfg_q <= po_cfg_q;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						inv_q  <= inv_q | rep_bad;
						last_q <= last_column;
						if (drain_go) begin
							col_q   <= '0;
							cols_q  <= colcnt;
							rem_q   <= rem_init;
							skip_q  <= mod_small(pidx_q, dc_eff);
							disk_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							col_q <= colcnt[COL_W-1:0];
						end
					end
				end
				ST_LOAD: begin
					if (disk_q >= dc_eff) begin
						// drain done: rotate parity
						pidx_q  <= (DC_W'(skip_q + 1'b1) == dc_eff) ? '0 :
						           DC_W'(skip_q + 1'b1);
						state_q <= last_q ? ST_PAD : ST_IDLE;
					end else if (disk_q == skip_q) begin
						disk_q <= disk_q + 1'b1;
					end else begin
						k_q     <= cols_q;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (avail) begin
						rem_q <= rem_q - 1'b1;
						k_q   <= k_q - 1'b1;
						if (k_q == CNT_W'(1)) begin
							disk_q  <= disk_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_PAD: begin
					if (avail)
						state_q <= ST_STATUS;
				end
				ST_STATUS: begin
					if (avail) begin
						col_q   <= '0;
						pidx_q  <= '0;
						inv_q   <= 1'b0;
						last_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (item_kind == KIND_STATUS)) |-> last_result)
		else $error("status item without last_result");

	a_shift_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> ((rem_q != '0) && (k_q != '0)))
		else $error("drain shifting with no bits left");

	a_skip_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (skip_q < dc_eff))
		else $error("parity disk outside the set");

	a_last_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_column) |=> in_stall)
		else $error("input taken right after last column");

	a_cmd_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(pcmd.push || pcmd.pad || pcmd.status) |-> avail)
		else $error("packer command while output register blocked");

endmodule

[sim/tb_raid_parity_recover_unstripe_core.sv]
// Self-checking testbench for the parity recovery / unstripe core: directed and random columns.
module tb_raid_parity_recover_unstripe_core;
	import rprs_pkg::*;

	typedef logic [MAX_DISKS-1:0][SYM_W-1:0] sym_vec_t;

	typedef struct packed {
		logic                   kind;
		logic [NIBBLE_BITS-1:0] nib;
		logic                   ok;
		logic                   last;
	} column_result_t;

	function automatic int live_disks(int v);
		if (v < 2)
			return 2;
		if (v > MAX_DISKS)
			return MAX_DISKS;
		return v;
	endfunction

	function automatic int live_bits(int v);
		if (v < 1)
			return 1;
		if (v > MAX_BLOCK_BITS)
			return MAX_BLOCK_BITS;
		return v;
	endfunction

	// Predicts the nibble/status stream and checks what the core emits.
	class rprs_scoreboard;
		column_result_t          awaited[$];
		column_result_t          fresh[$];
		int                      mismatches;
		logic [DC_W-1:0]         reg_disks;
		logic [BB_W-1:0]         reg_bits;
		logic                    reg_odd;
		logic [MAX_BLOCK_BITS-1:0] stripe[MAX_DISKS];
		int                      cols_held;
		int                      parity_disk;
		logic [NIBBLE_BITS-1:0]  accum;
		int                      fill;
		bit                      broken;

		function new();
			reg_disks  = DC_RESET;
			reg_bits   = BB_RESET;
			reg_odd    = PO_RESET;
			mismatches = 0;
			clear_set();
		endfunction

		function void clear_set();
			for (int i = 0; i < MAX_DISKS; i++)
				stripe[i] = '0;
			cols_held   = 0;
			parity_disk = 0;
			accum       = '0;
			fill        = 0;
			broken      = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DISK_COUNT: reg_disks = data[DC_W-1:0];
				REG_BLOCK_BITS: reg_bits = data[BB_W-1:0];
				REG_PARITY_ODD: reg_odd = data[0];
				default: ;
			endcase
		endfunction

		function void emit(logic kind, logic [NIBBLE_BITS-1:0] nib, logic ok);
			column_result_t r;
			r = {kind, nib, ok, 1'b0};
			fresh.push_back(r);
		endfunction

		function void push_bit(logic b);
			accum = {accum[NIBBLE_BITS-2:0], b};
			fill++;
			if (fill == NIBBLE_BITS) begin
				emit(KIND_DATA, accum, 1'b0);
				accum = '0;
				fill  = 0;
			end
		endfunction

		// read out every data disk of the stripe, parity disk skipped
		function void drain(int cols, int dc);
			int skip;
			skip = parity_disk % dc;
			for (int j = 0; j < dc; j++) begin
				if (j == skip)
					continue;
				for (int k = 0; k < cols; k++)
					push_bit(stripe[j][k]);
			end
			parity_disk = (skip + 1) % dc;
			cols_held   = 0;
		endfunction

		function void note_column(sym_vec_t s, logic lc);
			int                   dc;
			int                   bb;
			int                   ones;
			int                   erased;
			int                   spot;
			int                   col;
			logic [MAX_DISKS-1:0] bits;
			column_result_t       r;
			dc     = live_disks(reg_disks);
			bb     = live_bits(reg_bits);
			ones   = 0;
			erased = 0;
			spot   = 0;
			bits   = '0;
			fresh.delete();
			for (int i = 0; i < dc; i++) begin
				if (s[i][SYM_ERASE]) begin
					erased++;
					spot = i;
				end else begin
					bits[i] = s[i][0];
					ones += bits[i];
				end
			end
			if (erased > 1)
				broken = 1'b1;
			else if (logic'(ones & 1) != reg_odd) begin
				if (erased == 1)
					bits[spot] = 1'b1;
				else
					broken = 1'b1;
			end
			col = (cols_held >= bb) ? bb - 1 : cols_held;
			for (int i = 0; i < MAX_DISKS; i++)
				stripe[i][col] = bits[i];
			cols_held = col + 1;
			if (cols_held >= bb)
				drain(bb, dc);
			if (lc) begin
				if (cols_held > 0)
					drain(cols_held, dc);
				if (fill > 0)
					emit(KIND_DATA, NIBBLE_BITS'(accum << (NIBBLE_BITS - fill)), 1'b0);
				emit(KIND_STATUS, '0, !broken);
				clear_set();
			end
			for (int i = 0; i < fresh.size(); i++) begin
				r      = fresh[i];
				r.last = (i == fresh.size() - 1);
				awaited.push_back(r);
			end
		endfunction

		function void check(column_result_t got);
			column_result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind=%0d nibble=%h valid=%0d last=%0d",
						got.kind, got.nib, got.ok, got.last);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected kind=%0d nibble=%h valid=%0d last=%0d,",
						" got kind=%0d nibble=%h valid=%0d last=%0d"},
						want.kind, want.nib, want.ok, want.last,
						got.kind, got.nib, got.ok, got.last);
			end
		endfunction

		function void leftover();
			if (awaited.size() > 0) begin
				if (mismatches < 10)
					$display("%0d expected results never arrived", awaited.size());
				mismatches += awaited.size();
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 5000;
	// longest drain (six disks, sixteen bits) plus pad and status must fit; leave margin
	localparam int SETTLE_CYCLES  = 120;
	localparam int ITEM_TARGET    = 470;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [SYM_W-1:0] SYM_ZERO       = 2'd0;
	localparam logic [SYM_W-1:0] SYM_ONE        = 2'd1;
	localparam logic [SYM_W-1:0] SYM_ERASED     = 2'd2;
	localparam logic [SYM_W-1:0] SYM_ERASED_ALT = 2'd3;

	typedef enum int {COL_CLEAN, COL_ERASE_ONE, COL_MISMATCH, COL_DOUBLE, COL_NOISE} col_style_t;
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [SYM_W-1:0]       disk0_sym = '0;
	logic [SYM_W-1:0]       disk1_sym = '0;
	logic [SYM_W-1:0]       disk2_sym = '0;
	logic [SYM_W-1:0]       disk3_sym = '0;
	logic [SYM_W-1:0]       disk4_sym = '0;
	logic [SYM_W-1:0]       disk5_sym = '0;
	logic                   last_column = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   item_kind;
	logic [NIBBLE_BITS-1:0] nibble;
	logic                   set_valid;
	logic                   last_result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	rprs_scoreboard sb;
	int             tx_pct = 0;     // sender idle chance per cycle, percent
	int             rx_pct = 0;     // receiver stall chance per cycle, percent
	logic           rx_hold = 1'b0; // forces stall low while the core settles
	int             sent = 0;
	int             idle_cycles = 0;

	raid_parity_recover_unstripe_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.disk0_sym   (disk0_sym),
		.disk1_sym   (disk1_sym),
		.disk2_sym   (disk2_sym),
		.disk3_sym   (disk3_sym),
		.disk4_sym   (disk4_sym),
		.disk5_sym   (disk5_sym),
		.last_column (last_column),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.item_kind   (item_kind),
		.nibble      (nibble),
		.set_valid   (set_valid),
		.last_result (last_result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	// Receiver: check the item taken at this edge, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check({item_kind, nibble, set_valid, last_result});
		out_stall <= !rx_hold && ($urandom_range(0, 99) < rx_pct);
	end

	// Watchdog: cycles in a row where no channel moved an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// One column item. Valid either stays high into the next item or drops
	// for a random gap; never both in one step.
	task automatic send_col(input sym_vec_t s, input logic lc);
		int gap;
		gap = 0;
		while (tx_pct > 0 && $urandom_range(0, 99) < tx_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		disk0_sym   <= s[0];
		disk1_sym   <= s[1];
		disk2_sym   <= s[2];
		disk3_sym   <= s[3];
		disk4_sym   <= s[4];
		disk5_sym   <= s[5];
		last_column <= lc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_column(s, lc);
		sent++;
	endtask

	// Sender holds off until every predicted item has come out.
	task automatic pause_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Idle point for register writes: drained, then a drain's worth of quiet
	// cycles in case a drain with no nibble is still running.
	task automatic settle();
		pause_for_results();
		rx_hold <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] dc_data,
			input logic [CFG_DATA_W-1:0] bb_data, input logic [CFG_DATA_W-1:0] po_data,
			input bit stray);
		cfg_put(REG_DISK_COUNT, dc_data);
		cfg_put(REG_BLOCK_BITS, bb_data);
		cfg_put(REG_PARITY_ODD, po_data);
		// write to the unmapped index must change nothing
		if (stray)
			cfg_put(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input idle_mode_t m);
		case (m)
			IDLE_NONE:     begin tx_pct = 0;  rx_pct <= 0;  end
			IDLE_SENDER:   begin tx_pct = 83; rx_pct <= 0;  end
			IDLE_RECEIVER: begin tx_pct = 0;  rx_pct <= 83; end
			default:       begin tx_pct = 28; rx_pct <= 28; end
		endcase
	endtask

	// Column over dc live disks; unused disks get random junk.
	function automatic sym_vec_t make_column(input int dc, input logic odd, input col_style_t st);
		sym_vec_t             s;
		logic [MAX_DISKS-1:0] b;
		logic                 par;
		int                   p;
		int                   q;
		b   = MAX_DISKS'($urandom);
		par = 1'b0;
		for (int i = 0; i < MAX_DISKS; i++)
			s[i] = SYM_W'($urandom_range(0, 3));
		for (int i = 0; i < dc; i++)
			par ^= b[i];
		if (par != odd) begin
			p    = $urandom_range(0, dc - 1);
			b[p] = ~b[p];
		end
		for (int i = 0; i < dc; i++)
			s[i] = {1'b0, b[i]};
		p = $urandom_range(0, dc - 1);
		case (st)
			COL_ERASE_ONE:
				s[p] = $urandom_range(0, 1) ? SYM_ERASED : SYM_ERASED_ALT;
			COL_MISMATCH:
				s[p][0] = ~s[p][0];
			COL_DOUBLE: begin
				q    = (p + 1 + $urandom_range(0, dc - 2)) % dc;
				s[p] = SYM_ERASED;
				s[q] = $urandom_range(0, 1) ? SYM_ERASED : SYM_ERASED_ALT;
			end
			COL_NOISE:
				for (int i = 0; i < MAX_DISKS; i++)
					s[i] = SYM_W'($urandom_range(0, 3));
			default: ;
		endcase
		return s;
	endfunction

	function automatic sym_vec_t two_disk(input logic [SYM_W-1:0] d0, input logic [SYM_W-1:0] d1);
		sym_vec_t s;
		s    = sym_vec_t'({$urandom, $urandom});
		s[0] = d0;
		s[1] = d1;
		return s;
	endfunction

	initial begin
		int                    phase;
		int                    dcv;
		int                    bbv;
		int                    r;
		int                    dcl;
		int                    bbl;
		int                    nsets;
		int                    len;
		bit                    cut;
		bit                    flawed;
		logic                  odd;
		logic                  lc;
		logic [CFG_DATA_W-1:0] po_data;
		col_style_t            st;

		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: two disks, one-bit blocks, even parity ----
		// each column drains a single bit, alternating the parity disk
		set_idling(IDLE_NONE);
		configure(5'd2, 5'd1, 5'd0, 1'b0);
		send_col(two_disk(SYM_ZERO, SYM_ZERO), 1'b0);
		send_col(two_disk(SYM_ONE, SYM_ONE), 1'b0);
		send_col(two_disk(SYM_ERASED, SYM_ONE), 1'b0);     // erasure rebuilt to one
		send_col(two_disk(SYM_ZERO, SYM_ERASED_ALT), 1'b0); // code three counts as erased
		pause_for_results();
		send_col(two_disk(SYM_ERASED, SYM_ERASED), 1'b1);   // too many erasures
		send_col(two_disk(SYM_ONE, SYM_ZERO), 1'b1);        // parity mismatch, no erasure
		send_col(two_disk(SYM_ONE, SYM_ONE), 1'b1);         // clean one-column set

		// ---- directed: six disks, sixteen-bit blocks, odd parity ----
		// one full stripe, then the last column lands inside the next one
		settle();
		configure(5'd6, 5'd16, 5'd1, 1'b1);
		for (int c = 0; c < 18; c++)
			send_col(make_column(MAX_DISKS, 1'b1, (c % 2) ? COL_ERASE_ONE : COL_CLEAN), c == 17);

		// ---- random phases ----
		// Each phase: settle, new registers, one to three sets. Sometimes the
		// last set is cut short so the next settings land mid-stripe.
		phase = 0;
		dcl   = MAX_DISKS;
		odd   = 1'b1;
		while (sent < ITEM_TARGET) begin
			settle();
			set_idling(idle_mode_t'(phase % 4));
			dcv = $urandom_range(2, 6);
			if ($urandom_range(0, 9) >= 7) begin
				r   = $urandom_range(0, 2);
				dcv = (r == 2) ? 7 : r;
			end
			r = $urandom_range(0, 19);
			if (r < 12)
				bbv = $urandom_range(1, 6);
			else if (r < 15)
				bbv = $urandom_range(7, 16);
			else if (r < 17)
				bbv = 0;
			else
				bbv = $urandom_range(17, 31);
			po_data = CFG_DATA_W'($urandom);
			// upper data bits beyond the disk count field ride along at random
			configure(CFG_DATA_W'(($urandom_range(0, 3) << DC_W) | dcv), CFG_DATA_W'(bbv),
				po_data, $urandom_range(0, 3) == 0);
			dcl   = live_disks(dcv);
			bbl   = live_bits(bbv);
			odd   = po_data[0];
			nsets = $urandom_range(1, 3);
			cut   = ($urandom_range(0, 3) == 0);
			for (int s = 0; s < nsets; s++) begin
				len = $urandom_range(1, 2 * bbl + 2);
				if (len > 24)
					len = 24;
				flawed = ($urandom_range(0, 9) < 3);
				for (int c = 0; c < len; c++) begin
					if (flawed && $urandom_range(0, 6) == 0) begin
						r  = $urandom_range(0, 2);
						st = (r == 0) ? COL_MISMATCH : (r == 1) ? COL_DOUBLE : COL_NOISE;
					end else
						st = $urandom_range(0, 1) ? COL_ERASE_ONE : COL_CLEAN;
					lc = (c == len - 1) && !(cut && s == nsets - 1);
					send_col(make_column(dcl, odd, st), lc);
				end
				if ($urandom_range(0, 4) == 0)
					pause_for_results();
			end
			phase++;
		end
		// close whatever set is open
		send_col(make_column(dcl, odd, COL_CLEAN), 1'b1);

		pause_for_results();
		rx_hold <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.leftover();
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[raid_parity_recover_unstripe_core.f]
hw/rtl/rprs_pkg.sv
hw/rtl/rprs_repair.sv
hw/rtl/rprs_stripe.sv
hw/rtl/rprs_packer.sv
hw/rtl/raid_parity_recover_unstripe_core.sv
sim/tb_raid_parity_recover_unstripe_core.sv
